// ===== sv/gdn_pkg.sv =====
// Shared constants, types and tables for the Gregorian day number converter.
package gdn_pkg;

   // Day counts and limits of the proleptic Gregorian calendar.
   localparam int EPOCH_OFFSET  = 693595;
   localparam int DAYS_PER_400Y = 146097;
   localparam int MAX_SCALAR    = 3652059;

   // Years are biased by 399 so the days-before sum works on positive values
   // only; 400 years always hold exactly DAYS_PER_400Y days.
   localparam int YEAR_BIAS = 399;

   // Reciprocal of 146097/400, rounded down, for the year estimate.
   localparam int          YEAR_SHIFT = 32;
   localparam logic [23:0] YEAR_RECIP = 24'((64'd400 << YEAR_SHIFT) / 64'(DAYS_PER_400Y));

   // Reciprocal of 25, exact for dividends below 43690.
   localparam int          DIV25_SHIFT = 17;
   localparam logic [12:0] DIV25_RECIP = 13'd5243;

   // Reciprocal of 3057, rounded up, exact for dividends below 2**16.
   localparam int          MONTH_SHIFT = 28;
   localparam logic [16:0] MONTH_RECIP = 17'(((64'd1 << MONTH_SHIFT) + 64'd3056) / 64'd3057);

   // Conversion direction.
   typedef enum logic {
      OP_TO_DAYS = 1'b0,
      OP_TO_DATE = 1'b1
   } gdn_op_type;

   // Control that travels with every request through the pipeline.
   typedef struct packed {
      logic       valid;
      gdn_op_type opcode;
      logic       oor;
   } gdn_ctl_type;

   // Residues of the biased year modulo 4, 100 and 400.
   typedef struct packed {
      logic [1:0] r4;
      logic [6:0] r100;
      logic [8:0] r400;
   } gdn_res_type;

   // Days before month m: (3057*m - 3007)/100, rounded toward zero.
   function automatic logic signed [9:0] month_offset(input logic [3:0] m);
      logic signed [9:0] ofs;
      case (m)
         4'd0:    ofs = -10'sd30;
         4'd1:    ofs = 10'sd0;
         4'd2:    ofs = 10'sd31;
         4'd3:    ofs = 10'sd61;
         4'd4:    ofs = 10'sd92;
         4'd5:    ofs = 10'sd122;
         4'd6:    ofs = 10'sd153;
         4'd7:    ofs = 10'sd183;
         4'd8:    ofs = 10'sd214;
         4'd9:    ofs = 10'sd245;
         4'd10:   ofs = 10'sd275;
         4'd11:   ofs = 10'sd306;
         4'd12:   ofs = 10'sd336;
         4'd13:   ofs = 10'sd367;
         4'd14:   ofs = 10'sd397;
         4'd15:   ofs = 10'sd428;
         default: ofs = 10'sd0;
      endcase
      return ofs;
   endfunction

endpackage

// ===== sv/gdn_year_est.sv =====
// Stages one and two: epoch shift, range check and year estimate of a request.
module gdn_year_est import gdn_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  gdn_op_type         opcode,
   input  logic [13:0]        year,
   input  logic [3:0]         month,
   input  logic [4:0]         day_of_month,
   input  logic signed [22:0] day_number,
   output gdn_ctl_type        ctl,
   output logic [21:0]        scalar,
   output logic [13:0]        estimate,
   output logic [13:0]        year_out,
   output logic [3:0]         month_out,
   output logic [4:0]         day_out
);

   localparam logic signed [23:0] EPOCH_S = 24'(EPOCH_OFFSET);
   localparam logic signed [23:0] MAX_S   = 24'(MAX_SCALAR);

   logic signed [23:0] scalar_full;
   gdn_ctl_type        ctl1_in, ctl1_ff, ctl2_ff;
   logic [21:0]        scalar1_in, scalar1_ff, scalar2_ff;
   logic [13:0]        year1_ff, year2_ff;
   logic [3:0]         month1_ff, month2_ff;
   logic [4:0]         day1_ff, day2_ff;
   logic [45:0]        est_product;
   logic [13:0]        estimate2_in, estimate2_ff;

   // Shift the day number to a count from the start of year 1 and check its range.
   assign scalar_full    = $signed({day_number[22], day_number}) + EPOCH_S;
   assign scalar1_in     = scalar_full[21:0];
   assign ctl1_in.valid  = accept;
   assign ctl1_in.opcode = opcode;
   assign ctl1_in.oor    = (opcode == OP_TO_DATE) &&
                           ((scalar_full < 24'sd1) || (scalar_full > MAX_S));

   // Year estimate: scalar * 400/146097, never above the true quotient.
   assign est_product  = 46'(scalar1_ff) * 46'(YEAR_RECIP);
   assign estimate2_in = est_product[YEAR_SHIFT +: 14];

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff.valid <= 1'b0;
         ctl2_ff.valid <= 1'b0;
      end else begin
         ctl1_ff.valid <= ctl1_in.valid;
         ctl2_ff.valid <= ctl1_ff.valid;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ctl1_ff.opcode <= ctl1_in.opcode;
      ctl1_ff.oor    <= ctl1_in.oor;
      scalar1_ff     <= scalar1_in;
      year1_ff       <= year;
      month1_ff      <= month;
      day1_ff        <= day_of_month;
      ctl2_ff.opcode <= ctl1_ff.opcode;
      ctl2_ff.oor    <= ctl1_ff.oor;
      scalar2_ff     <= scalar1_ff;
      estimate2_ff   <= estimate2_in;
      year2_ff       <= year1_ff;
      month2_ff      <= month1_ff;
      day2_ff        <= day1_ff;
   end

   assign ctl       = ctl2_ff;
   assign scalar    = scalar2_ff;
   assign estimate  = estimate2_ff;
   assign year_out  = year2_ff;
   assign month_out = month2_ff;
   assign day_out   = day2_ff;

endmodule

// ===== sv/gdn_days_before.sv =====
// Stages three and four: days before a biased year and its residues.
module gdn_days_before import gdn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  gdn_ctl_type ctl_in,
   input  logic [21:0] scalar_in,
   input  logic [13:0] estimate_in,
   input  logic [13:0] year_in,
   input  logic [3:0]  month_in,
   input  logic [4:0]  day_in,
   output gdn_ctl_type ctl,
   output logic [21:0] scalar,
   output logic [14:0] base,
   output logic [22:0] days,
   output gdn_res_type res,
   output logic [3:0]  month_out,
   output logic [4:0]  day_out
);

   gdn_ctl_type ctl3_ff, ctl4_ff;
   logic [21:0] scalar3_ff, scalar4_ff;
   logic [3:0]  month3_ff, month4_ff;
   logic [4:0]  day3_ff, day4_ff;
   logic [14:0] base3_in, base3_ff, base4_ff;
   logic [12:0] quarter3, quarter4;
   logic [25:0] cent_product;
   logic [7:0]  cent3_in, cent3_ff;
   logic [14:0] cent_x100, rem100;
   gdn_res_type res4_in, res4_ff;
   logic [22:0] days4_in, days4_ff;

   // Biased year: the estimate for date requests, year minus one plus 400 otherwise.
   assign base3_in = ((ctl_in.opcode == OP_TO_DATE) ? {1'b0, estimate_in} : {1'b0, year_in})
                     + 15'(YEAR_BIAS);

   // Centuries: (year/4)/25 by reciprocal multiply.
   assign quarter3     = base3_in[14:2];
   assign cent_product = 26'(quarter3) * 26'(DIV25_RECIP);
   assign cent3_in     = cent_product[DIV25_SHIFT +: 8];

   // Residues and the days in all years up to the biased year.
   assign quarter4     = base3_ff[14:2];
   assign cent_x100    = 15'(cent3_ff) * 15'd100;
   assign rem100       = base3_ff - cent_x100;
   assign res4_in.r4   = base3_ff[1:0];
   assign res4_in.r100 = rem100[6:0];
   assign res4_in.r400 = 9'(cent3_ff[1:0]) * 9'd100 + 9'(rem100[6:0]);
   assign days4_in     = 23'(base3_ff) * 23'd365 + 23'(quarter4) - 23'(cent3_ff)
                         + 23'(cent3_ff[7:2]);

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff.valid <= 1'b0;
         ctl4_ff.valid <= 1'b0;
      end else begin
         ctl3_ff.valid <= ctl_in.valid;
         ctl4_ff.valid <= ctl3_ff.valid;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ctl3_ff.opcode <= ctl_in.opcode;
      ctl3_ff.oor    <= ctl_in.oor;
      scalar3_ff     <= scalar_in;
      month3_ff      <= month_in;
      day3_ff        <= day_in;
      base3_ff       <= base3_in;
      cent3_ff       <= cent3_in;
      ctl4_ff.opcode <= ctl3_ff.opcode;
      ctl4_ff.oor    <= ctl3_ff.oor;
      scalar4_ff     <= scalar3_ff;
      month4_ff      <= month3_ff;
      day4_ff        <= day3_ff;
      base4_ff       <= base3_ff;
      res4_ff        <= res4_in;
      days4_ff       <= days4_in;
   end

   assign ctl       = ctl4_ff;
   assign scalar    = scalar4_ff;
   assign base      = base4_ff;
   assign days      = days4_ff;
   assign res       = res4_ff;
   assign month_out = month4_ff;
   assign day_out   = day4_ff;

endmodule

// ===== sv/gdn_split.sv =====
// Stages five to seven: year correction, month and day split, result registers.
module gdn_split import gdn_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  gdn_ctl_type        ctl_in,
   input  logic [21:0]        scalar_in,
   input  logic [14:0]        base_in,
   input  logic [22:0]        days_in,
   input  gdn_res_type        res_in,
   input  logic [3:0]         month_in,
   input  logic [4:0]         day_in,
   output logic               strobe,
   output logic signed [22:0] result_day_number,
   output logic [13:0]        result_year,
   output logic [3:0]         result_month,
   output logic [4:0]         result_day,
   output logic               out_of_range
);

   localparam logic [24:0] DAYS_400Y_W = 25'(DAYS_PER_400Y);
   localparam logic [25:0] EPOCH_W     = 26'(EPOCH_OFFSET);

   logic [4:0]         carry4, carry100, carry400;
   logic [4:0]         hit4, hit100, hit400;
   logic signed [24:0] cum_days [5];
   logic [3:0]         leap_v;
   logic [3:0]         found;
   logic [1:0]         pick;
   logic signed [24:0] scalar_s, prev_days, rem_diff;
   logic [1:0]         adj0;
   logic signed [9:0]  mofs0;
   logic [25:0]        total0;

   gdn_ctl_type        ctl5_ff, ctl6_ff;
   logic [13:0]        year5_in, year5_ff, year6_ff;
   logic [8:0]         rem5_in, rem5_ff;
   logic               leap5_in, leap5_ff;
   logic [22:0]        daynum5_in, daynum5_ff, daynum6_ff;
   logic [8:0]         rem6_in, rem6_ff;
   logic [15:0]        month_num;
   logic [32:0]        month_product;
   logic [3:0]         month6_in, month6_ff;
   logic [9:0]         day7_full;

   logic               strobe_ff;
   logic [22:0]        daynum7_in, daynum7_ff;
   logic [13:0]        year7_in, year7_ff;
   logic [3:0]         month7_in, month7_ff;
   logic [4:0]         day7_in, day7_ff;
   logic               oor7_in, oor7_ff;

   // Days before each of the five years from the base on, less 400 years.
   always_comb begin
      for (int k = 0; k < 5; k++) begin
         carry4[k]   = ({1'b0, res_in.r4} + 3'(k)) >= 3'd4;
         carry100[k] = (8'(res_in.r100) + 8'(k)) >= 8'd100;
         carry400[k] = (10'(res_in.r400) + 10'(k)) >= 10'd400;
         hit4[k]     = ({1'b0, res_in.r4} + 3'(k)) == 3'd4;
         hit100[k]   = (8'(res_in.r100) + 8'(k)) == 8'd100;
         hit400[k]   = (10'(res_in.r400) + 10'(k)) == 10'd400;
         cum_days[k] = $signed(25'(days_in) + 25'(365 * k) + 25'(carry4[k])
                       + 25'(carry400[k]) - 25'(carry100[k]) - DAYS_400Y_W);
      end
   end

   // Leap flags of the four candidate years and the first year that reaches the scalar.
   assign scalar_s = $signed({3'b000, scalar_in});
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         leap_v[j] = hit4[j + 1] && (!hit100[j + 1] || hit400[j + 1]);
         found[j]  = cum_days[j + 1] >= scalar_s;
      end
   end

   always_comb begin
      if (found[0]) begin
         pick = 2'd0;
      end else if (found[1]) begin
         pick = 2'd1;
      end else if (found[2]) begin
         pick = 2'd2;
      end else begin
         pick = 2'd3;
      end
   end

   always_comb begin
      case (pick)
         2'd0:    prev_days = cum_days[0];
         2'd1:    prev_days = cum_days[1];
         2'd2:    prev_days = cum_days[2];
         2'd3:    prev_days = cum_days[3];
         default: prev_days = cum_days[0];
      endcase
   end

   assign rem_diff = scalar_s - prev_days;
   assign year5_in = 14'(base_in - 15'(YEAR_BIAS) + 15'(pick));
   assign rem5_in  = rem_diff[8:0];
   assign leap5_in = leap_v[pick];

   // Date to day number: day, month offset, leap correction, days before the year.
   assign adj0  = (month_in > 4'd2) ? (leap_v[0] ? 2'd1 : 2'd2) : 2'd0;
   assign mofs0 = month_offset(month_in);
   assign total0 = 26'(day_in) + {{16{mofs0[9]}}, mofs0} + {cum_days[0][24], cum_days[0]}
                   - 26'(adj0) - EPOCH_W;
   assign daynum5_in = total0[22:0];

   // Fold the leap day into the day of year, then month = (rem*100 + 3007)/3057.
   always_comb begin
      rem6_in = rem5_ff;
      if (rem5_ff > 9'd59) begin
         rem6_in = rem5_ff + 9'd2;
         if (leap5_ff) begin
            rem6_in = (rem6_in > 9'd62) ? rem6_in - 9'd1 : rem6_in - 9'd2;
         end
      end
   end

   assign month_num     = 16'(rem6_in) * 16'd100 + 16'd3007;
   assign month_product = 33'(month_num) * 33'(MONTH_RECIP);
   assign month6_in     = month_product[MONTH_SHIFT +: 4];

   // Day of month and the zeroing of unused result fields.
   assign day7_full = 10'(rem6_ff) - month_offset(month6_ff);

   always_comb begin
      daynum7_in = '0;
      year7_in   = '0;
      month7_in  = '0;
      day7_in    = '0;
      oor7_in    = 1'b0;
      if (ctl6_ff.opcode == OP_TO_DAYS) begin
         daynum7_in = daynum6_ff;
      end else if (ctl6_ff.oor) begin
         oor7_in = 1'b1;
      end else begin
         year7_in  = year6_ff;
         month7_in = month6_ff;
         day7_in   = day7_full[4:0];
      end
   end

   // Valid bits and the result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl5_ff.valid <= 1'b0;
         ctl6_ff.valid <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         ctl5_ff.valid <= ctl_in.valid;
         ctl6_ff.valid <= ctl5_ff.valid;
         strobe_ff     <= ctl6_ff.valid;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ctl5_ff.opcode <= ctl_in.opcode;
      ctl5_ff.oor    <= ctl_in.oor;
      year5_ff       <= year5_in;
      rem5_ff        <= rem5_in;
      leap5_ff       <= leap5_in;
      daynum5_ff     <= daynum5_in;
      ctl6_ff.opcode <= ctl5_ff.opcode;
      ctl6_ff.oor    <= ctl5_ff.oor;
      year6_ff       <= year5_ff;
      rem6_ff        <= rem6_in;
      month6_ff      <= month6_in;
      daynum6_ff     <= daynum5_ff;
      daynum7_ff     <= daynum7_in;
      year7_ff       <= year7_in;
      month7_ff      <= month7_in;
      day7_ff        <= day7_in;
      oor7_ff        <= oor7_in;
   end

   assign strobe            = strobe_ff;
   assign result_day_number = $signed(daynum7_ff);
   assign result_year       = year7_ff;
   assign result_month      = month7_ff;
   assign result_day        = day7_ff;
   assign out_of_range      = oor7_ff;

endmodule

// ===== sv/gregorian_day_number_converter_core.sv =====
// Top level of the Gregorian date and day number converter.
// A request's result is strobed after it has passed the seven register stages of the pipeline
// (two multiplies feed the year search).
// Throughput: one request per cycle; busy stays low and the receiver cannot stall.
// Reset: synchronous, active high; it clears the valid bits of all stages.
module gregorian_day_number_converter_core import gdn_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_opcode,
   input  logic [13:0]        req_year,
   input  logic [3:0]         req_month,
   input  logic [4:0]         req_day_of_month,
   input  logic signed [22:0] req_day_number,
   output logic               rsp_strobe,
   output logic signed [22:0] rsp_result_day_number,
   output logic [13:0]        rsp_result_year,
   output logic [3:0]         rsp_result_month,
   output logic [4:0]         rsp_result_day,
   output logic               rsp_out_of_range
);

   gdn_ctl_type ctl_a, ctl_b;
   logic [21:0] scalar_a, scalar_b;
   logic [13:0] estimate_a, year_a;
   logic [3:0]  month_a, month_b;
   logic [4:0]  day_a, day_b;
   logic [14:0] base_b;
   logic [22:0] days_b;
   gdn_res_type res_b;
   gdn_op_type  opcode;

   // The pipeline never holds off a request.
   assign busy   = 1'b0;
   assign opcode = gdn_op_type'(req_opcode);

   gdn_year_est u_year_est (
      .clock        (clock),
      .reset        (reset),
      .accept       (start && !busy),
      .opcode       (opcode),
      .year         (req_year),
      .month        (req_month),
      .day_of_month (req_day_of_month),
      .day_number   (req_day_number),
      .ctl          (ctl_a),
      .scalar       (scalar_a),
      .estimate     (estimate_a),
      .year_out     (year_a),
      .month_out    (month_a),
      .day_out      (day_a)
   );

   gdn_days_before u_days_before (
      .clock       (clock),
      .reset       (reset),
      .ctl_in      (ctl_a),
      .scalar_in   (scalar_a),
      .estimate_in (estimate_a),
      .year_in     (year_a),
      .month_in    (month_a),
      .day_in      (day_a),
      .ctl         (ctl_b),
      .scalar      (scalar_b),
      .base        (base_b),
      .days        (days_b),
      .res         (res_b),
      .month_out   (month_b),
      .day_out     (day_b)
   );

   gdn_split u_split (
      .clock             (clock),
      .reset             (reset),
      .ctl_in            (ctl_b),
      .scalar_in         (scalar_b),
      .base_in           (base_b),
      .days_in           (days_b),
      .res_in            (res_b),
      .month_in          (month_b),
      .day_in            (day_b),
      .strobe            (rsp_strobe),
      .result_day_number (rsp_result_day_number),
      .result_year       (rsp_result_year),
      .result_month      (rsp_result_month),
      .result_day        (rsp_result_day),
      .out_of_range      (rsp_out_of_range)
   );

endmodule

// ===== sv/gdn_checker.sv =====
// Port-level checks of the converter, bound to the top level.
module gdn_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               req_opcode,
   input logic [13:0]        req_year,
   input logic [3:0]         req_month,
   input logic [4:0]         req_day_of_month,
   input logic signed [22:0] req_day_number,
   input logic               rsp_strobe,
   input logic signed [22:0] rsp_result_day_number,
   input logic [13:0]        rsp_result_year,
   input logic [3:0]         rsp_result_month,
   input logic [4:0]         rsp_result_day,
   input logic               rsp_out_of_range
);

   // Every accepted request is answered with a result strobe.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##7 rsp_strobe)
      else $error("request not answered after seven cycles");

   // An out-of-range result carries no date and no day number.
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_out_of_range) |->
         (rsp_result_year == 14'd0 && rsp_result_month == 4'd0 &&
          rsp_result_day == 5'd0 && rsp_result_day_number == 23'sd0))
      else $error("out-of-range result with nonzero fields");

   // A date to day number request leaves the date fields and the range flag clear.
   a_days_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !$past(req_opcode, 7)) |->
         (rsp_result_year == 14'd0 && rsp_result_month == 4'd0 &&
          rsp_result_day == 5'd0 && !rsp_out_of_range))
      else $error("day number result with date fields set");

   // A converted date has a month from 1 to 12, a day of at least 1, a year from 1 to 9999 and a zero day number.
   a_date_bounds: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_opcode, 7) && !rsp_out_of_range) |->
         (rsp_result_month >= 4'd1 && rsp_result_month <= 4'd12 &&
          rsp_result_day >= 5'd1 && rsp_result_year >= 14'd1 &&
          rsp_result_year <= 14'd9999 && rsp_result_day_number == 23'sd0))
      else $error("converted date out of bounds");

endmodule

bind gregorian_day_number_converter_core gdn_checker u_gdn_checker (.*);
